// ----- sv/terrain_surface_area_accumulator_top_assert.svh -----
// Assertion macros for the terrain surface area accumulator checker.
// No dependencies; taken in by the checker file with `include.
`ifndef TERRAIN_SURFACE_AREA_ACCUMULATOR_TOP_ASSERT_SVH
`define TERRAIN_SURFACE_AREA_ACCUMULATOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TSA_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TSA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/tsa_pkg.sv -----
// Shared constants and controller/datapath command and status types for the
// terrain surface area accumulator. No dependencies.
package tsa_pkg;

	localparam int ROW_LEN_DEF     = 4096;
	localparam int HEIGHT_BITS_DEF = 12;
	localparam int FRAC_BITS_DEF   = 8;

	localparam int CFG_W = 13;
	localparam int SUM_W = 63;

	localparam int APB_ADDR_W = 2;
	localparam int APB_DATA_W = 32;

	localparam logic [CFG_W-1:0]      ROW_LENGTH_RESET = CFG_W'(4096);
	localparam logic [APB_ADDR_W-1:0] ADDR_ROW_LENGTH  = APB_ADDR_W'(0);

	typedef struct packed {
		logic load;          // take a sample transaction
		logic rd_right;      // line store address at column + 1
		logic mem_wr;        // write current sample into the line store
		logic capture_here;  // hold the previous-row sample of this column
		logic sq_start;      // load both square root units
		logic mul;           // multiply the two lengths
		logic acc;           // saturating add into the sum
		logic advance;       // step the column position
		logic emit;          // load the result register and restart the grid
	} tsa_cmd_t;

	typedef struct packed {
		logic eval;      // sample closes a cell
		logic sq_done;   // both square roots finished
		logic out_full;  // result register still occupied
		logic last;      // held sample ends the grid
	} tsa_stat_t;

endpackage

// ----- sv/tsa_in_if.sv -----
// Sample channel: valid/ready handshake with height and grid markers.
// Depends on tsa_pkg.
interface tsa_in_if import tsa_pkg::*; #(
	parameter int HEIGHT_BITS = HEIGHT_BITS_DEF
);
	logic                   valid;
	logic                   ready;
	logic [HEIGHT_BITS-1:0] height;
	logic                   first_sample;
	logic                   last_sample;

	modport source (output valid, output height, output first_sample, output last_sample,
		input ready);
	modport sink (input valid, input height, input first_sample, input last_sample,
		output ready);
endinterface

// ----- sv/tsa_out_if.sv -----
// Result channel: valid/ready handshake with area sum and saturation flag.
// Depends on tsa_pkg.
interface tsa_out_if import tsa_pkg::*;;
	logic             valid;
	logic             ready;
	logic [SUM_W-1:0] area_sum;
	logic             saturated;

	modport source (output valid, output area_sum, output saturated, input ready);
	modport sink (input valid, input area_sum, input saturated, output ready);
endinterface

// ----- sv/tsa_isqrt.sv -----
// Bit-serial integer square root, one root bit per cycle.
// Depends on tsa_pkg for its default radicand width.
module tsa_isqrt import tsa_pkg::*; #(
	parameter int VW = 2 * (HEIGHT_BITS_DEF + FRAC_BITS_DEF)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [VW-1:0]         radicand,
	output logic                  busy,
	output logic [(VW+1)/2-1:0]   root
);
	localparam int RW   = (VW + 1) / 2;
	localparam int PW   = 2 * RW;
	localparam int CNTW = (RW > 1) ? $clog2(RW) : 1;

	logic [PW-1:0]   rad_q;
	logic [RW:0]     rem_q;
	logic [RW-1:0]   root_q;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q;

	logic [RW+2:0] rem_raw;
	logic [RW+2:0] trial;
	logic          fits;

	assign rem_raw = {rem_q, rad_q[PW-1:PW-2]};
	assign trial   = (RW+3)'({root_q, 2'b01});
	assign fits    = (rem_raw >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNTW'(RW - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= PW'(radicand);
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[PW-3:0], 2'b00};
			if (fits) begin
				rem_q  <= (RW+1)'(rem_raw - trial);
				root_q <= {root_q[RW-2:0], 1'b1};
			end else begin
				rem_q  <= rem_raw[RW:0];
				root_q <= {root_q[RW-2:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign root = root_q;
endmodule

// ----- sv/tsa_datapath.sv -----
// Datapath: line store, grid position, two square root units, multiplier,
// saturating sum and result register. Depends on tsa_pkg, tsa_isqrt, tsa_out_if.
module tsa_datapath import tsa_pkg::*; #(
	parameter int ROW_LEN     = ROW_LEN_DEF,
	parameter int HEIGHT_BITS = HEIGHT_BITS_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  tsa_cmd_t               cmd,
	output tsa_stat_t              stat,
	input  logic [CFG_W-1:0]       row_length,
	input  logic [HEIGHT_BITS-1:0] height,
	input  logic                   first_sample,
	input  logic                   last_sample,
	tsa_out_if.source              result
);
	localparam int AW   = (ROW_LEN > 1) ? $clog2(ROW_LEN) : 1;
	localparam int LW   = $clog2(ROW_LEN + 1);
	localparam int CMPW = (CFG_W > LW) ? CFG_W : LW;
	localparam int VW   = 2 * HEIGHT_BITS + 2 * FRAC_BITS;
	localparam int RW   = (VW + 1) / 2;
	localparam int PW   = 2 * RW;
	localparam int DW   = 2 * HEIGHT_BITS;

	logic [HEIGHT_BITS-1:0] mem [ROW_LEN];

	logic [HEIGHT_BITS-1:0] h_q;
	logic                   last_q;
	logic [AW-1:0]          col_q;
	logic                   first_row_q;
	logic [SUM_W-1:0]       acc_q;
	logic                   sat_q;
	logic [HEIGHT_BITS-1:0] rdata_q;
	logic [HEIGHT_BITS-1:0] here_q;
	logic [PW-1:0]          prod_q;
	logic                   out_valid_q;
	logic [SUM_W-1:0]       out_sum_q;
	logic                   out_sat_q;

	logic [CMPW-1:0]        cfg_ext;
	logic [LW-1:0]          len_eff;
	logic [LW-1:0]          col_inc;
	logic [AW-1:0]          mem_addr;
	logic [HEIGHT_BITS-1:0] d_row;
	logic [HEIGHT_BITS-1:0] d_col;
	logic [DW-1:0]          sq_row;
	logic [DW-1:0]          sq_col;
	logic [VW-1:0]          rad_row;
	logic [VW-1:0]          rad_col;
	logic                   busy_row;
	logic                   busy_col;
	logic [RW-1:0]          root_row;
	logic [RW-1:0]          root_col;
	logic [SUM_W:0]         sum_next;

	// Effective row length, clamped to at least 2 and at most the line store.
	always_comb begin
		cfg_ext = CMPW'(row_length);
		if (cfg_ext < CMPW'(2)) begin
			len_eff = LW'(2);
		end else if (cfg_ext > CMPW'(ROW_LEN)) begin
			len_eff = LW'(ROW_LEN);
		end else begin
			len_eff = LW'(cfg_ext);
		end
	end

	assign col_inc  = LW'(col_q) + LW'(1);
	assign mem_addr = cmd.rd_right ? AW'(col_inc) : col_q;

	assign stat.eval     = !first_row_q && (col_inc < len_eff);
	assign stat.sq_done  = !busy_row && !busy_col;
	assign stat.out_full = out_valid_q;
	assign stat.last     = last_q;

	// Line store, one port: read every cycle, write on command.
	always_ff @(posedge clk) begin
		if (cmd.mem_wr) begin
			mem[mem_addr] <= h_q;
		end
		rdata_q <= mem[mem_addr];
	end

	// Absolute steps and radicands (1 + d^2) << 2F; rdata_q holds the right neighbour.
	always_comb begin
		d_row   = (h_q > here_q) ? (h_q - here_q) : (here_q - h_q);
		d_col   = (rdata_q > here_q) ? (rdata_q - here_q) : (here_q - rdata_q);
		sq_row  = DW'(d_row) * DW'(d_row);
		sq_col  = DW'(d_col) * DW'(d_col);
		rad_row = {sq_row + DW'(1), {(2*FRAC_BITS){1'b0}}};
		rad_col = {sq_col + DW'(1), {(2*FRAC_BITS){1'b0}}};
	end

	tsa_isqrt #(.VW(VW)) u_sqrt_row (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.sq_start),
		.radicand (rad_row),
		.busy     (busy_row),
		.root     (root_row)
	);

	tsa_isqrt #(.VW(VW)) u_sqrt_col (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.sq_start),
		.radicand (rad_col),
		.busy     (busy_col),
		.root     (root_col)
	);

	assign sum_next = {1'b0, acc_q} + (SUM_W+1)'(prod_q);

	// Sample payload, captured previous-row sample, product and result payload.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			h_q <= height;
		end
		if (cmd.capture_here) begin
			here_q <= rdata_q;
		end
		if (cmd.mul) begin
			prod_q <= PW'(root_row) * PW'(root_col);
		end
		if (cmd.emit) begin
			out_sum_q <= acc_q;
			out_sat_q <= sat_q;
		end
	end

	// Grid position, sum and result handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q      <= 1'b0;
			col_q       <= '0;
			first_row_q <= 1'b1;
			acc_q       <= '0;
			sat_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				last_q <= last_sample;
				if (first_sample) begin
					col_q       <= '0;
					first_row_q <= 1'b1;
					acc_q       <= '0;
					sat_q       <= 1'b0;
				end
			end
			if (cmd.acc) begin
				if (sum_next[SUM_W]) begin
					acc_q <= '1;
					sat_q <= 1'b1;
				end else begin
					acc_q <= sum_next[SUM_W-1:0];
				end
			end
			if (cmd.advance) begin
				if (col_inc >= len_eff) begin
					col_q       <= '0;
					first_row_q <= 1'b0;
				end else begin
					col_q <= AW'(col_inc);
				end
			end
			if (cmd.emit) begin
				col_q       <= '0;
				first_row_q <= 1'b1;
				acc_q       <= '0;
				sat_q       <= 1'b0;
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result.valid     = out_valid_q;
	assign result.area_sum  = out_sum_q;
	assign result.saturated = out_sat_q;
endmodule

// ----- sv/tsa_ctrl.sv -----
// Controller: sequences one sample through read, square root, multiply and
// accumulate (cell-closing samples only), then position update or result emit. Depends on tsa_pkg.
module tsa_ctrl import tsa_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  tsa_stat_t stat,
	output tsa_cmd_t  cmd
);
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD_HERE,
		ST_RD_RIGHT,
		ST_SQ_START,
		ST_SQ_RUN,
		ST_MUL,
		ST_ACC,
		ST_FINISH
	} state_t;

	state_t state_q;
	state_t state_next;

	always_comb begin
		cmd        = '0;
		state_next = state_q;
		in_ready   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load   = 1'b1;
					state_next = ST_RD_HERE;
				end
			end
			ST_RD_HERE: begin
				if (stat.eval) begin
					state_next = ST_RD_RIGHT;
				end else begin
					cmd.mem_wr = 1'b1;
					state_next = ST_FINISH;
				end
			end
			ST_RD_RIGHT: begin
				cmd.rd_right     = 1'b1;
				cmd.capture_here = 1'b1;
				state_next       = ST_SQ_START;
			end
			ST_SQ_START: begin
				cmd.sq_start = 1'b1;
				cmd.mem_wr   = 1'b1;
				state_next   = ST_SQ_RUN;
			end
			ST_SQ_RUN: begin
				if (stat.sq_done) begin
					state_next = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul    = 1'b1;
				state_next = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc    = 1'b1;
				state_next = ST_FINISH;
			end
			ST_FINISH: begin
				if (stat.last) begin
					if (!stat.out_full) begin
						cmd.emit   = 1'b1;
						state_next = ST_IDLE;
					end
				end else begin
					cmd.advance = 1'b1;
					state_next  = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end
endmodule

// ----- sv/terrain_surface_area_accumulator_top.sv -----
// Top level of the terrain surface area accumulator: APB register, controller
// and datapath. Depends on tsa_pkg, tsa_in_if, tsa_out_if, tsa_ctrl, tsa_datapath.
//
// Usage:
//   samples : height samples of a grid in raster order; first_sample restarts
//             the grid, last_sample closes it and produces one result.
//   result  : one transaction per grid carrying the summed cell areas
//             (16 fraction bits at default settings) and a saturation flag.
//   APB     : row_length at byte address 0; write only while the block is idle.
// Timing:
//   A sample that closes a cell waits for the two bit-serial square root units,
//   which produce one root bit per cycle; any other sample skips them.
//   The result is presented in the cycle after the final sample's work ends.
// Reset:
//   Asynchronous, active low. Clears position, sum, flag and the result slot;
//   row_length returns to 4096. The line store is not cleared.
// Back-pressure:
//   The result register holds while the receiver stalls; samples keep being
//   taken, and only a further grid-closing sample waits for the slot to free.
module terrain_surface_area_accumulator_top import tsa_pkg::*; #(
	parameter int ROW_LEN     = ROW_LEN_DEF,
	parameter int HEIGHT_BITS = HEIGHT_BITS_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	tsa_in_if.sink                samples,
	tsa_out_if.source             result,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);
	logic [CFG_W-1:0] row_length_q;
	tsa_cmd_t         cmd;
	tsa_stat_t        stat;
	logic             cfg_wr;

	// Register write on the access phase; the port never inserts wait states.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_ROW_LENGTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_length_q <= ROW_LENGTH_RESET;
		end else if (cfg_wr) begin
			row_length_q <= pwdata[CFG_W-1:0];
		end
	end

	// Read back the stored value, zero elsewhere.
	assign prdata = (paddr == ADDR_ROW_LENGTH) ? APB_DATA_W'(row_length_q) : '0;

	// Sequencer: one sample at a time.
	tsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (samples.valid),
		.in_ready (samples.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Line store, square roots, product, sum and result register.
	tsa_datapath #(
		.ROW_LEN     (ROW_LEN),
		.HEIGHT_BITS (HEIGHT_BITS),
		.FRAC_BITS   (FRAC_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.row_length   (row_length_q),
		.height       (samples.height),
		.first_sample (samples.first_sample),
		.last_sample  (samples.last_sample),
		.result       (result)
	);
endmodule

// ----- sv/tsa_checker.sv -----
// Port-level checker for the terrain surface area accumulator, bound to the top.
// Depends on tsa_pkg and terrain_surface_area_accumulator_top_assert.svh.
`include "terrain_surface_area_accumulator_top_assert.svh"

module tsa_checker import tsa_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input logic [SUM_W-1:0] area_sum,
	input logic             saturated
);
	// Hold a stalled result.
	`TSA_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")
	`TSA_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(area_sum) && $stable(saturated), "result changed while stalled")
	// A clamped sum stays at its maximum.
	`TSA_ASSERT_IMPLIES(a_sat_max, clk, arst_n, out_valid && saturated, &area_sum, "saturated sum below maximum")
	// One sample at a time.
	`TSA_ASSERT_NEXT(a_one_item, clk, arst_n, in_valid && in_ready, !in_ready, "sample taken while busy")
	// A result only leaves the sequencer when it is not taking samples.
	`TSA_ASSERT_IMPLIES(a_emit_busy, clk, arst_n, $rose(out_valid), !$past(in_ready), "result raised from idle")
endmodule

bind terrain_surface_area_accumulator_top tsa_checker u_tsa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (samples.valid),
	.in_ready  (samples.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.area_sum  (result.area_sum),
	.saturated (result.saturated)
);
